@@ rtl/gjk_pkg.sv @@
// gjk_pkg: shared types and constants for the gjk simplex step core
// used by gjk_vop, gjk_ctrl and gjk_simplex_collision_step_core; no dependencies
package gjk_pkg;

  // fixed field widths of the stream ports
  localparam int PT_W        = 16;
  localparam int DIR_W       = 54;
  localparam int STEP_W      = 8;
  localparam int OUT_TDATA_W = 168;
  localparam int IN_TDATA_W  = 48;

  localparam logic [STEP_W-1:0] MAX_STEPS_RST = 8'd32;
  localparam logic [STEP_W-1:0] STEP_SAT      = 8'hFF;

  // result kinds carried on out_tuser
  typedef enum logic [2:0] {
    V_CONT   = 3'd0,
    V_HIT    = 3'd1,
    V_SEP    = 3'd2,
    V_IDLE   = 3'd3,
    V_GIVEUP = 3'd4
  } verdict_t;

  // sequencer states: idle, final and one per vector operation of the reduction
  typedef enum logic [4:0] {
    ST_IDLE, ST_DOTD,
    ST_L1, ST_L2, ST_L3,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8, ST_T9,
    ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6,
    ST_FIN
  } state_t;

  // wide operand sources
  typedef enum logic [2:0] {W_DIR, W_T, W_N, W_AB, W_AC, W_AD} wsel_t;

  // narrow operand sources
  typedef enum logic [2:0] {N_AO, N_AB, N_AC, N_AD, N_P} nsel_t;

  // request to the shared vector unit
  typedef struct packed {
    logic go;
    logic is_cross;
    logic neg;
  } vop_cmd_t;

  // status back from the shared vector unit
  typedef struct packed {
    logic done;
    logic pos;
  } vop_sts_t;

endpackage

@@ rtl/gjk_vop.sv @@
// gjk_vop: shared multiply-accumulate unit for cross products and dot signs
// one product per cycle, registered product, then accumulate; uses gjk_pkg
module gjk_vop #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gjk_pkg::vop_cmd_t                   cmd,
  input  logic signed [gjk_pkg::DIR_W-1:0]    w_x,
  input  logic signed [gjk_pkg::DIR_W-1:0]    w_y,
  input  logic signed [gjk_pkg::DIR_W-1:0]    w_z,
  input  logic signed [COORD_BITS:0]          n_x,
  input  logic signed [COORD_BITS:0]          n_y,
  input  logic signed [COORD_BITS:0]          n_z,
  output gjk_pkg::vop_sts_t                   sts,
  output logic signed [gjk_pkg::DIR_W-1:0]    r_x,
  output logic signed [gjk_pkg::DIR_W-1:0]    r_y,
  output logic signed [gjk_pkg::DIR_W-1:0]    r_z
);

  localparam int DW = gjk_pkg::DIR_W;
  localparam int NW = COORD_BITS + 1;
  localparam int OW = NW + 1;
  localparam int PW = DW + OW;
  localparam int AW = PW + 2;

  localparam logic [2:0] LAST_CROSS = 3'd5;
  localparam logic [2:0] LAST_DOT   = 3'd2;

  logic                 run_r, run_nxt;
  logic [2:0]           k_r, k_nxt;
  logic                 kind_r, kind_nxt;
  logic                 neg_r, neg_nxt;
  logic                 pv_r, pv_nxt;
  logic [2:0]           pk_r, pk_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [DW-1:0] rx_r, ry_r, rz_r, rx_nxt, ry_nxt, rz_nxt;
  logic                 done_r, done_nxt;
  logic                 pos_r, pos_nxt;

  logic signed [DW-1:0] w_term;
  logic signed [NW-1:0] n_sel;
  logic signed [OW-1:0] n_term;
  logic                 tsign;
  logic [2:0]           last_k;
  logic                 start;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] sum;
  logic                 first;

  assign last_k = kind_r ? LAST_CROSS : LAST_DOT;
  assign start  = cmd.go && !run_r && !pv_r && !done_r;

  // operand pair and sign of the current term
  always_comb begin
    w_term = w_x;
    n_sel  = n_x;
    tsign  = 1'b0;
    if (kind_r) begin
      unique case (k_r)
        3'd0:    begin w_term = w_y; n_sel = n_z; tsign = 1'b0; end
        3'd1:    begin w_term = w_z; n_sel = n_y; tsign = 1'b1; end
        3'd2:    begin w_term = w_z; n_sel = n_x; tsign = 1'b0; end
        3'd3:    begin w_term = w_x; n_sel = n_z; tsign = 1'b1; end
        3'd4:    begin w_term = w_x; n_sel = n_y; tsign = 1'b0; end
        default: begin w_term = w_y; n_sel = n_x; tsign = 1'b1; end
      endcase
    end else begin
      unique case (k_r)
        3'd0:    begin w_term = w_x; n_sel = n_x; end
        3'd1:    begin w_term = w_y; n_sel = n_y; end
        default: begin w_term = w_z; n_sel = n_z; end
      endcase
    end
    n_term = {n_sel[NW-1], n_sel};
    if (tsign ^ neg_r) begin
      n_term = OW'(0) - {n_sel[NW-1], n_sel};
    end
  end

  // the one multiplier
  assign prod_nxt = w_term * n_term;

  // accumulate path
  assign prod_ext = {{(AW-PW){prod_r[PW-1]}}, prod_r};
  assign sum      = acc_r + prod_ext;
  assign first    = kind_r ? !pk_r[0] : (pk_r == 3'd0);

  // issue and accumulate control
  always_comb begin
    run_nxt  = run_r;
    k_nxt    = k_r;
    kind_nxt = kind_r;
    neg_nxt  = neg_r;
    pv_nxt   = 1'b0;
    pk_nxt   = pk_r;
    acc_nxt  = acc_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    rz_nxt   = rz_r;
    done_nxt = 1'b0;
    pos_nxt  = pos_r;
    if (start) begin
      run_nxt  = 1'b1;
      k_nxt    = 3'd0;
      kind_nxt = cmd.is_cross;
      neg_nxt  = cmd.neg;
    end else if (run_r) begin
      pv_nxt = 1'b1;
      pk_nxt = k_r;
      k_nxt  = k_r + 3'd1;
      if (k_r == last_k) begin
        run_nxt = 1'b0;
      end
    end
    if (pv_r) begin
      acc_nxt = first ? prod_ext : sum;
      if (kind_r && pk_r[0]) begin
        unique case (pk_r[2:1])
          2'd0:    rx_nxt = sum[DW-1:0];
          2'd1:    ry_nxt = sum[DW-1:0];
          default: rz_nxt = sum[DW-1:0];
        endcase
      end
      if (pk_r == last_k) begin
        done_nxt = 1'b1;
        pos_nxt  = !sum[AW-1] && (sum != '0);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      pv_r   <= pv_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    kind_r <= kind_nxt;
    neg_r  <= neg_nxt;
    pk_r   <= pk_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    rz_r   <= rz_nxt;
    pos_r  <= pos_nxt;
  end

  assign sts.done = done_r;
  assign sts.pos  = pos_r;
  assign r_x = rx_r;
  assign r_y = ry_r;
  assign r_z = rz_r;

  // a finished operation has drained the pipeline
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!run_r && !pv_r))
    else $error("vop done while still busy");

  // done is a single pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("vop done held");

  // last issued term leaves a product behind and stops issuing
  a_last_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && (k_r == last_k)) |=> (pv_r && !run_r))
    else $error("vop issue did not stop on last term");

endmodule

@@ rtl/gjk_ctrl.sv @@
// gjk_ctrl: sequencer, simplex and direction state of the gjk step core
// drives the shared gjk_vop unit; uses gjk_pkg
module gjk_ctrl #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic                                start,
  input  logic [gjk_pkg::PT_W-1:0]            pt_x,
  input  logic [gjk_pkg::PT_W-1:0]            pt_y,
  input  logic [gjk_pkg::PT_W-1:0]            pt_z,
  input  logic                                cfg_we,
  input  logic [gjk_pkg::STEP_W-1:0]          cfg_wdata,
  output logic                                idle,
  output logic                                fin_valid,
  input  logic                                fin_ready,
  output gjk_pkg::verdict_t                   fin_verdict,
  output logic [gjk_pkg::DIR_W-1:0]           fin_dir_x,
  output logic [gjk_pkg::DIR_W-1:0]           fin_dir_y,
  output logic [gjk_pkg::DIR_W-1:0]           fin_dir_z
);

  localparam int C  = COORD_BITS;
  localparam int NW = COORD_BITS + 1;
  localparam int DW = gjk_pkg::DIR_W;

  typedef struct packed {
    logic [C-1:0] x;
    logic [C-1:0] y;
    logic [C-1:0] z;
  } pt_t;

  typedef struct packed {
    logic [NW-1:0] x;
    logic [NW-1:0] y;
    logic [NW-1:0] z;
  } nvec_t;

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
  } wvec_t;

  gjk_pkg::state_t   state_r, state_nxt;
  pt_t               s_r [4];
  pt_t               s_nxt [4];
  pt_t               p_r, p_nxt;
  logic [2:0]        count_r, count_nxt;
  wvec_t             dir_r, dir_nxt;
  wvec_t             t_r, t_nxt;
  wvec_t             n_r, n_nxt;
  logic              active_r, active_nxt;
  logic [gjk_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [gjk_pkg::STEP_W-1:0] max_r, max_nxt;
  gjk_pkg::verdict_t verdict_r, verdict_nxt;

  pt_t               in_pt;
  nvec_t             ab, ac, ad, ao, pn, in_neg;
  wvec_t             wop, res;
  nvec_t             nop;
  gjk_pkg::wsel_t    wsel;
  gjk_pkg::nsel_t    nsel;
  gjk_pkg::vop_cmd_t cmd;
  gjk_pkg::vop_sts_t sts;
  gjk_pkg::verdict_t end_vd;
  logic              end_active;
  logic [2:0]        push_count;
  logic              pos_go;

  function automatic logic [NW-1:0] sx(input logic [C-1:0] v);
    sx = {v[C-1], v};
  endfunction

  function automatic logic [DW-1:0] wx(input logic [NW-1:0] v);
    wx = {{(DW-NW){v[NW-1]}}, v};
  endfunction

  function automatic wvec_t wxv(input nvec_t v);
    wvec_t r;
    r.x = wx(v.x);
    r.y = wx(v.y);
    r.z = wx(v.z);
    wxv = r;
  endfunction

  // low coordinate bits of the incoming point
  assign in_pt.x = pt_x[C-1:0];
  assign in_pt.y = pt_y[C-1:0];
  assign in_pt.z = pt_z[C-1:0];

  // edge vectors and ao from the newest point; held point and negated input
  assign ab.x = sx(s_r[1].x) - sx(s_r[0].x);
  assign ab.y = sx(s_r[1].y) - sx(s_r[0].y);
  assign ab.z = sx(s_r[1].z) - sx(s_r[0].z);
  assign ac.x = sx(s_r[2].x) - sx(s_r[0].x);
  assign ac.y = sx(s_r[2].y) - sx(s_r[0].y);
  assign ac.z = sx(s_r[2].z) - sx(s_r[0].z);
  assign ad.x = sx(s_r[3].x) - sx(s_r[0].x);
  assign ad.y = sx(s_r[3].y) - sx(s_r[0].y);
  assign ad.z = sx(s_r[3].z) - sx(s_r[0].z);
  assign ao.x = NW'(0) - sx(s_r[0].x);
  assign ao.y = NW'(0) - sx(s_r[0].y);
  assign ao.z = NW'(0) - sx(s_r[0].z);
  assign pn.x = sx(p_r.x);
  assign pn.y = sx(p_r.y);
  assign pn.z = sx(p_r.z);
  assign in_neg.x = NW'(0) - sx(in_pt.x);
  assign in_neg.y = NW'(0) - sx(in_pt.y);
  assign in_neg.z = NW'(0) - sx(in_pt.z);

  // operation issued in each state
  always_comb begin
    cmd  = '0;
    wsel = gjk_pkg::W_DIR;
    nsel = gjk_pkg::N_AO;
    unique case (state_r)
      gjk_pkg::ST_DOTD: begin cmd.go = 1'b1; wsel = gjk_pkg::W_DIR; nsel = gjk_pkg::N_P;  end
      gjk_pkg::ST_L1:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_AB;  nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_L2:   begin cmd = 3'b110;  wsel = gjk_pkg::W_AB;  nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_L3:   begin cmd = 3'b110;  wsel = gjk_pkg::W_T;   nsel = gjk_pkg::N_AB; end
      gjk_pkg::ST_T1:   begin cmd = 3'b110;  wsel = gjk_pkg::W_AB;  nsel = gjk_pkg::N_AC; end
      gjk_pkg::ST_T2:   begin cmd = 3'b110;  wsel = gjk_pkg::W_N;   nsel = gjk_pkg::N_AC; end
      gjk_pkg::ST_T3:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_T;   nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_T4:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_AC;  nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_T5:   begin cmd = 3'b110;  wsel = gjk_pkg::W_AC;  nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_T6:   begin cmd = 3'b110;  wsel = gjk_pkg::W_T;   nsel = gjk_pkg::N_AC; end
      gjk_pkg::ST_T7:   begin cmd = 3'b111;  wsel = gjk_pkg::W_N;   nsel = gjk_pkg::N_AB; end
      gjk_pkg::ST_T8:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_T;   nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_T9:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_N;   nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_X1:   begin cmd = 3'b110;  wsel = gjk_pkg::W_AB;  nsel = gjk_pkg::N_AC; end
      gjk_pkg::ST_X2:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_T;   nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_X3:   begin cmd = 3'b110;  wsel = gjk_pkg::W_AC;  nsel = gjk_pkg::N_AD; end
      gjk_pkg::ST_X4:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_T;   nsel = gjk_pkg::N_AO; end
      gjk_pkg::ST_X5:   begin cmd = 3'b110;  wsel = gjk_pkg::W_AD;  nsel = gjk_pkg::N_AB; end
      gjk_pkg::ST_X6:   begin cmd.go = 1'b1; wsel = gjk_pkg::W_T;   nsel = gjk_pkg::N_AO; end
      default:          begin cmd = '0; end
    endcase
  end

  // operand selection
  always_comb begin
    unique case (wsel)
      gjk_pkg::W_DIR: wop = dir_r;
      gjk_pkg::W_T:   wop = t_r;
      gjk_pkg::W_N:   wop = n_r;
      gjk_pkg::W_AB:  wop = wxv(ab);
      gjk_pkg::W_AC:  wop = wxv(ac);
      default:        wop = wxv(ad);
    endcase
    unique case (nsel)
      gjk_pkg::N_AO: nop = ao;
      gjk_pkg::N_AB: nop = ab;
      gjk_pkg::N_AC: nop = ac;
      gjk_pkg::N_AD: nop = ad;
      default:       nop = pn;
    endcase
  end

  gjk_vop #(
    .COORD_BITS(COORD_BITS)
  ) u_vop (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .w_x   (wop.x),
    .w_y   (wop.y),
    .w_z   (wop.z),
    .n_x   (nop.x),
    .n_y   (nop.y),
    .n_z   (nop.z),
    .sts   (sts),
    .r_x   (res.x),
    .r_y   (res.y),
    .r_z   (res.z)
  );

  assign pos_go     = sts.done && sts.pos;
  assign end_vd     = (step_r >= max_r) ? gjk_pkg::V_GIVEUP : gjk_pkg::V_CONT;
  assign end_active = (step_r < max_r);
  assign push_count = ((count_r < 3'd3) ? count_r : 3'd3) + 3'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gjk_pkg::ST_IDLE: begin
        if (acc) begin
          state_nxt = (start || !active_r) ? gjk_pkg::ST_FIN : gjk_pkg::ST_DOTD;
        end
      end
      gjk_pkg::ST_DOTD: begin
        if (sts.done) begin
          if (!sts.pos)               state_nxt = gjk_pkg::ST_FIN;
          else if (push_count == 3'd2) state_nxt = gjk_pkg::ST_L1;
          else if (push_count == 3'd3) state_nxt = gjk_pkg::ST_T1;
          else                         state_nxt = gjk_pkg::ST_X1;
        end
      end
      gjk_pkg::ST_L1: if (sts.done) state_nxt = sts.pos ? gjk_pkg::ST_L2 : gjk_pkg::ST_FIN;
      gjk_pkg::ST_L2: if (sts.done) state_nxt = gjk_pkg::ST_L3;
      gjk_pkg::ST_L3: if (sts.done) state_nxt = gjk_pkg::ST_FIN;
      gjk_pkg::ST_T1: if (sts.done) state_nxt = gjk_pkg::ST_T2;
      gjk_pkg::ST_T2: if (sts.done) state_nxt = gjk_pkg::ST_T3;
      gjk_pkg::ST_T3: if (sts.done) state_nxt = sts.pos ? gjk_pkg::ST_T4 : gjk_pkg::ST_T7;
      gjk_pkg::ST_T4: if (sts.done) state_nxt = sts.pos ? gjk_pkg::ST_T5 : gjk_pkg::ST_L1;
      gjk_pkg::ST_T5: if (sts.done) state_nxt = gjk_pkg::ST_T6;
      gjk_pkg::ST_T6: if (sts.done) state_nxt = gjk_pkg::ST_FIN;
      gjk_pkg::ST_T7: if (sts.done) state_nxt = gjk_pkg::ST_T8;
      gjk_pkg::ST_T8: if (sts.done) state_nxt = sts.pos ? gjk_pkg::ST_L1 : gjk_pkg::ST_T9;
      gjk_pkg::ST_T9: if (sts.done) state_nxt = gjk_pkg::ST_FIN;
      gjk_pkg::ST_X1: if (sts.done) state_nxt = gjk_pkg::ST_X2;
      gjk_pkg::ST_X2: if (sts.done) state_nxt = sts.pos ? gjk_pkg::ST_T1 : gjk_pkg::ST_X3;
      gjk_pkg::ST_X3: if (sts.done) state_nxt = gjk_pkg::ST_X4;
      gjk_pkg::ST_X4: if (sts.done) state_nxt = sts.pos ? gjk_pkg::ST_T1 : gjk_pkg::ST_X5;
      gjk_pkg::ST_X5: if (sts.done) state_nxt = gjk_pkg::ST_X6;
      gjk_pkg::ST_X6: if (sts.done) state_nxt = sts.pos ? gjk_pkg::ST_T1 : gjk_pkg::ST_FIN;
      default:        if (fin_ready) state_nxt = gjk_pkg::ST_IDLE;
    endcase
  end

  // state data updates
  always_comb begin
    for (int i = 0; i < 4; i++) s_nxt[i] = s_r[i];
    p_nxt       = p_r;
    count_nxt   = count_r;
    dir_nxt     = dir_r;
    t_nxt       = t_r;
    n_nxt       = n_r;
    active_nxt  = active_r;
    step_nxt    = step_r;
    verdict_nxt = verdict_r;
    unique case (state_r)
      gjk_pkg::ST_IDLE: begin
        if (acc) begin
          p_nxt = in_pt;
          if (start) begin
            s_nxt[0]    = in_pt;
            count_nxt   = 3'd1;
            dir_nxt     = wxv(in_neg);
            active_nxt  = 1'b1;
            step_nxt    = '0;
            verdict_nxt = gjk_pkg::V_CONT;
          end else if (!active_r) begin
            verdict_nxt = gjk_pkg::V_IDLE;
          end
        end
      end
      gjk_pkg::ST_DOTD: begin
        if (sts.done) begin
          if (sts.pos) begin
            s_nxt[3]  = s_r[2];
            s_nxt[2]  = s_r[1];
            s_nxt[1]  = s_r[0];
            s_nxt[0]  = p_r;
            count_nxt = push_count;
            if (step_r != gjk_pkg::STEP_SAT) step_nxt = step_r + 1'b1;
          end else begin
            verdict_nxt = gjk_pkg::V_SEP;
            active_nxt  = 1'b0;
          end
        end
      end
      gjk_pkg::ST_L1: begin
        if (sts.done && !sts.pos) begin
          count_nxt   = 3'd1;
          dir_nxt     = wxv(ao);
          verdict_nxt = end_vd;
          active_nxt  = end_active;
        end
      end
      gjk_pkg::ST_L3: begin
        if (sts.done) begin
          count_nxt   = 3'd2;
          dir_nxt     = res;
          verdict_nxt = end_vd;
          active_nxt  = end_active;
        end
      end
      gjk_pkg::ST_T1: if (sts.done) n_nxt = res;
      gjk_pkg::ST_L2, gjk_pkg::ST_T2, gjk_pkg::ST_T5, gjk_pkg::ST_T7,
      gjk_pkg::ST_X1, gjk_pkg::ST_X3, gjk_pkg::ST_X5: begin
        if (sts.done) t_nxt = res;
      end
      gjk_pkg::ST_T6: begin
        if (sts.done) begin
          s_nxt[1]    = s_r[2];
          count_nxt   = 3'd2;
          dir_nxt     = res;
          verdict_nxt = end_vd;
          active_nxt  = end_active;
        end
      end
      gjk_pkg::ST_T9: begin
        if (sts.done) begin
          count_nxt   = 3'd3;
          verdict_nxt = end_vd;
          active_nxt  = end_active;
          if (sts.pos) begin
            dir_nxt = n_r;
          end else begin
            dir_nxt.x = DW'(0) - n_r.x;
            dir_nxt.y = DW'(0) - n_r.y;
            dir_nxt.z = DW'(0) - n_r.z;
            s_nxt[1]  = s_r[2];
            s_nxt[2]  = s_r[1];
          end
        end
      end
      // face (a,c,d)
      gjk_pkg::ST_X4: begin
        if (pos_go) begin
          s_nxt[1] = s_r[2];
          s_nxt[2] = s_r[3];
        end
      end
      // face (a,d,b), otherwise the origin is enclosed
      gjk_pkg::ST_X6: begin
        if (pos_go) begin
          s_nxt[1] = s_r[3];
          s_nxt[2] = s_r[1];
        end else if (sts.done) begin
          verdict_nxt = gjk_pkg::V_HIT;
          active_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  assign max_nxt = cfg_we ? cfg_wdata : max_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gjk_pkg::ST_IDLE;
      count_r  <= '0;
      active_r <= 1'b0;
      step_r   <= '0;
      max_r    <= gjk_pkg::MAX_STEPS_RST;
      dir_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      active_r <= active_nxt;
      step_r   <= step_nxt;
      max_r    <= max_nxt;
      dir_r    <= dir_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) s_r[i] <= s_nxt[i];
    p_r       <= p_nxt;
    t_r       <= t_nxt;
    n_r       <= n_nxt;
    verdict_r <= verdict_nxt;
  end

  assign idle        = (state_r == gjk_pkg::ST_IDLE);
  assign fin_valid   = (state_r == gjk_pkg::ST_FIN);
  assign fin_verdict = verdict_r;
  assign fin_dir_x   = dir_r.x;
  assign fin_dir_y   = dir_r.y;
  assign fin_dir_z   = dir_r.z;

endmodule

@@ rtl/gjk_simplex_collision_step_core.sv @@
// gjk_simplex_collision_step_core: top level of the gjk simplex step block
// stream ports and result register around gjk_ctrl; uses gjk_pkg
//
// Usage: each input transfer carries one support point of the Minkowski
// difference, found along the direction of the previous result. in_tuser
// set opens a new query (search along the negated start point first).
// Every input transfer gives exactly one output transfer: out_tuser holds
// the verdict (continue, collision, separated, idle, gave up) and out_tdata
// the next direction, zero unless the verdict is continue. cfg_we writes
// max_steps, the number of accepted points per query before it gives up.
// Each vector operation on the shared multiplier issues its products (3 for
// a dot, 6 for a cross) one after another, then accumulates the last one and
// signals done. A start or idle item goes from the idle state straight to the
// final step; any other point runs a dot test first and, if it is accepted,
// the line, triangle or tetrahedron reduction. out_tvalid rises once the
// result register loads. in_tready is high only while the sequencer is idle,
// which it is again the cycle after the result register loads. The result
// register lets the next item be taken while a result waits; a stalled
// receiver holds the sequencer at its final step. Reset (rst_n low,
// synchronous) clears the query, the direction and sets max_steps to 32.
module gjk_simplex_collision_step_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // point_x [15:0], point_y [31:16], point_z [47:32]
  input  logic [gjk_pkg::IN_TDATA_W-1:0]        in_tdata,
  // start_req
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // dir_x [53:0], dir_y [107:54], dir_z [161:108], zero pad [167:162]
  output logic [gjk_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // verdict
  output logic [2:0]                            out_tuser,
  input  logic                                  cfg_we,
  input  logic [gjk_pkg::STEP_W-1:0]            cfg_wdata
);

  localparam int DW  = gjk_pkg::DIR_W;
  localparam int PW  = gjk_pkg::PT_W;
  localparam int PAD = gjk_pkg::OUT_TDATA_W - 3 * DW;

  logic              in_acc;
  logic              idle;
  logic              fin_valid, fin_ready;
  gjk_pkg::verdict_t fin_verdict;
  logic [DW-1:0]     fin_dir_x, fin_dir_y, fin_dir_z;
  logic              cont;

  logic                               out_valid_r, out_valid_nxt;
  logic [gjk_pkg::OUT_TDATA_W-1:0]    out_tdata_r, out_tdata_nxt;
  logic [2:0]                         out_tuser_r, out_tuser_nxt;

  assign in_tready = idle;
  assign in_acc    = in_tvalid && idle;

  gjk_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .start       (in_tuser),
    .pt_x        (in_tdata[PW-1:0]),
    .pt_y        (in_tdata[2*PW-1:PW]),
    .pt_z        (in_tdata[3*PW-1:2*PW]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .idle        (idle),
    .fin_valid   (fin_valid),
    .fin_ready   (fin_ready),
    .fin_verdict (fin_verdict),
    .fin_dir_x   (fin_dir_x),
    .fin_dir_y   (fin_dir_y),
    .fin_dir_z   (fin_dir_z)
  );

  // result register, loads when empty or being drained
  assign fin_ready = !out_valid_r || out_tready;
  assign cont      = (fin_verdict == gjk_pkg::V_CONT);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (fin_valid && fin_ready) begin
      out_valid_nxt = 1'b1;
      out_tuser_nxt = fin_verdict;
      out_tdata_nxt = cont ? {PAD'(0), fin_dir_z, fin_dir_y, fin_dir_x} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

@@ test/gjk_simplex_collision_step_core_tb.sv @@
// gjk_simplex_collision_step_core_tb: self-checking bench for the gjk simplex step core
// predicts every verdict and search direction in a scoreboard class; uses gjk_pkg
`timescale 1ns / 1ps

module gjk_simplex_collision_step_core_tb;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  typedef struct {
    gjk_pkg::verdict_t        verdict;
    logic [gjk_pkg::DIR_W-1:0] dx;
    logic [gjk_pkg::DIR_W-1:0] dy;
    logic [gjk_pkg::DIR_W-1:0] dz;
  } result_t;

  // predictor of the simplex reduction plus queue of pending results
  class gjk_scoreboard;
    vec_t      pts[4];
    int        npts;
    vec_t      search;
    bit        active;
    int        steps;
    int        step_limit;
    result_t   pending[$];
    int        errors;
    int        n_results;
    int        n_verdict[5];

    function void clear();
      npts = 0; search = '{0, 0, 0}; active = 0; steps = 0; step_limit = 32;
      for (int i = 0; i < 4; i++) pts[i] = '{0, 0, 0};
    endfunction

    function vec_t vsub(vec_t a, vec_t b);
      vec_t r;
      r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
      return r;
    endfunction

    function vec_t vneg(vec_t a);
      vec_t r;
      r.x = -a.x; r.y = -a.y; r.z = -a.z;
      return r;
    endfunction

    function vec_t vcross(vec_t a, vec_t b);
      vec_t r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
    endfunction

    // exact sign test using 128-bit accumulation
    function bit dot_pos(vec_t u, vec_t v);
      logic signed [127:0] s;
      s = 128'(signed'(u.x)) * 128'(signed'(v.x)) + 128'(signed'(u.y)) * 128'(signed'(v.y))
        + 128'(signed'(u.z)) * 128'(signed'(v.z));
      return s > 0;
    endfunction

    function void set3(int n, vec_t a, vec_t b, vec_t c);
      pts[0] = a; pts[1] = b; pts[2] = c; npts = n;
    endfunction

    function void line_case(vec_t a, vec_t b);
      vec_t ab, ao;
      ab = vsub(b, a); ao = vneg(a);
      if (dot_pos(ab, ao)) begin
        set3(2, a, b, b); search = vcross(vcross(ab, ao), ab);
      end else begin
        set3(1, a, a, a); search = ao;
      end
    endfunction

    function void tri_case(vec_t a, vec_t b, vec_t c);
      vec_t ab, ac, ao, n;
      ab = vsub(b, a); ac = vsub(c, a); ao = vneg(a); n = vcross(ab, ac);
      if (dot_pos(vcross(n, ac), ao)) begin
        if (dot_pos(ac, ao)) begin
          set3(2, a, c, c); search = vcross(vcross(ac, ao), ac);
        end else line_case(a, b);
      end else if (dot_pos(vcross(ab, n), ao)) begin
        line_case(a, b);
      end else if (dot_pos(n, ao)) begin
        set3(3, a, b, c); search = n;
      end else begin
        set3(3, a, c, b); search = vneg(n);
      end
    endfunction

    function bit tetra_case(vec_t a, vec_t b, vec_t c, vec_t d);
      vec_t ab, ac, ad, ao;
      ab = vsub(b, a); ac = vsub(c, a); ad = vsub(d, a); ao = vneg(a);
      if (dot_pos(vcross(ab, ac), ao)) begin tri_case(a, b, c); return 0; end
      if (dot_pos(vcross(ac, ad), ao)) begin tri_case(a, c, d); return 0; end
      if (dot_pos(vcross(ad, ab), ao)) begin tri_case(a, d, b); return 0; end
      return 1;
    endfunction

    function void note_input(bit start, logic [gjk_pkg::IN_TDATA_W-1:0] data);
      vec_t p;
      result_t r;
      bit hit;
      p.x = longint'(signed'(data[15:0]));
      p.y = longint'(signed'(data[31:16]));
      p.z = longint'(signed'(data[47:32]));
      if (start) begin
        set3(1, p, p, p); search = vneg(p); active = 1; steps = 0;
        r.verdict = gjk_pkg::V_CONT;
      end else if (!active) begin
        r.verdict = gjk_pkg::V_IDLE;
      end else if (!dot_pos(search, p)) begin
        r.verdict = gjk_pkg::V_SEP; active = 0;
      end else begin
        hit = 0;
        if (steps < 255) steps++;
        pts[3] = pts[2]; pts[2] = pts[1]; pts[1] = pts[0]; pts[0] = p;
        npts = (npts < 3 ? npts : 3) + 1;
        if (npts == 2) line_case(pts[0], pts[1]);
        else if (npts == 3) tri_case(pts[0], pts[1], pts[2]);
        else hit = tetra_case(pts[0], pts[1], pts[2], pts[3]);
        if (hit) begin r.verdict = gjk_pkg::V_HIT; active = 0; end
        else if (steps >= step_limit) begin r.verdict = gjk_pkg::V_GIVEUP; active = 0; end
        else r.verdict = gjk_pkg::V_CONT;
      end
      if (r.verdict == gjk_pkg::V_CONT) begin
        r.dx = search.x[gjk_pkg::DIR_W-1:0];
        r.dy = search.y[gjk_pkg::DIR_W-1:0];
        r.dz = search.z[gjk_pkg::DIR_W-1:0];
      end else begin
        r.dx = '0; r.dy = '0; r.dz = '0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] verdict, logic [gjk_pkg::OUT_TDATA_W-1:0] data);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending: verdict %0d", verdict);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_results++;
      if (verdict <= 4) n_verdict[verdict]++;
      if (verdict !== e.verdict) begin
        $error("verdict: expected %0d, actual %0d", e.verdict, verdict); errors++;
      end
      if (data[53:0] !== e.dx) begin
        $error("dir_x: expected %h, actual %h", e.dx, data[53:0]); errors++;
      end
      if (data[107:54] !== e.dy) begin
        $error("dir_y: expected %h, actual %h", e.dy, data[107:54]); errors++;
      end
      if (data[161:108] !== e.dz) begin
        $error("dir_z: expected %h, actual %h", e.dz, data[161:108]); errors++;
      end
      if (data[167:162] !== 6'd0) begin
        $error("pad: expected 0, actual %h", data[167:162]); errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [gjk_pkg::IN_TDATA_W-1:0]    in_tdata;
  logic                              in_tuser;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [gjk_pkg::OUT_TDATA_W-1:0]   out_tdata;
  logic [2:0]                        out_tuser;
  logic                              cfg_we;
  logic [gjk_pkg::STEP_W-1:0]        cfg_wdata;

  gjk_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  longint cycles;
  int  n_items;

  gjk_simplex_collision_step_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 800000) begin
        $display("gjk_simplex_collision_step_core_tb failed");
        $finish;
      end
    end
  end

  // result side: random stalls, check every transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transfer, with optional idle cycles first; the block is never
  // ready in the cycle right after a transfer, so the first wait costs nothing
  task automatic send_point(bit start, int px, int py, int pz);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1;
    in_tuser  <= start;
    in_tdata  <= {pz[15:0], py[15:0], px[15:0]};
    do @(posedge clk); while (!in_tready);
    sb.note_input(start, {pz[15:0], py[15:0], px[15:0]});
    n_items++;
    in_tvalid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= v[7:0];
    @(posedge clk);
    cfg_we    <= 0;
    sb.step_limit = v;
  endtask

  function automatic int rnd_coord(int mag);
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 32767 : -32768;
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  // well-formed query: points roughly along the last reported direction
  task automatic run_query(int mag, int len);
    int px, py, pz;
    send_point(1, rnd_coord(mag), rnd_coord(mag), rnd_coord(mag));
    for (int k = 0; k < len && sb.active; k++) begin
      px = rnd_coord(mag); py = rnd_coord(mag); pz = rnd_coord(mag);
      if ($urandom_range(3) != 0) begin
        // nudge toward the search direction so most points are accepted
        px = (sb.search.x > 0) ? (px < 0 ? -px : px) : (sb.search.x < 0 ? (px > 0 ? -px : px) : px);
        py = (sb.search.y > 0) ? (py < 0 ? -py : py) : (sb.search.y < 0 ? (py > 0 ? -py : py) : py);
        pz = (sb.search.z > 0) ? (pz < 0 ? -pz : pz) : (sb.search.z < 0 ? (pz > 0 ? -pz : pz) : pz);
      end
      send_point(0, px, py, pz);
    end
  endtask

  task automatic set_phase(int ph);
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  initial begin
    sb = new();
    sb.clear();
    n_items = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = 0;
    out_tready = 0; cfg_we = 0; cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: idle item, extremes, zero direction, collision tetrahedron
    send_point(0, 5, 5, 5);
    send_point(1, 32767, -32768, 0);
    send_point(0, -32768, 32767, -1);
    send_point(1, 0, 0, 0);
    send_point(0, 1, 1, 1);
    send_point(1, 10, 0, 0);
    send_point(0, -10, 1, 0);
    send_point(0, -10, -1, 5);
    send_point(0, -10, -1, -5);
    send_point(1, 100, 0, 0);
    send_point(0, -100, 0, 0);
    send_point(0, 100, 0, 0);
    send_point(1, 20, 20, 20);
    send_point(0, -20, -20, -20);
    send_point(1, -32768, -32768, -32768);
    send_point(0, 32767, 32767, 32767);
    send_point(1, 3, 4, 5);
    send_point(1, -3, -4, -5);
    send_point(0, 0, 0, 0);

    // limits at the extremes, including zero and one
    write_limit(0);
    run_query(100, 3);
    write_limit(1);
    run_query(100, 3);
    write_limit(255);
    run_query(1000, 30);
    write_limit(2);
    run_query(50, 4);

    // random phases over several step limits; noise items mixed in
    for (int ph = 0; ph < 8; ph++) begin
      write_limit(ph == 3 ? 255 : $urandom_range(1, 12));
      set_phase(ph);
      // about 42 items per phase, about 400 in all
      while (n_items < 64 + 42 * (ph + 1)) begin
        if ($urandom_range(5) == 0)
          send_point($urandom_range(1), rnd_coord(32768), rnd_coord(32768), rnd_coord(32768));
        else run_query($urandom_range(1) ? 40 : 32768, $urandom_range(2, 8));
      end
      // hold off until every pending result is back
      while (sb.pending.size() != 0) @(posedge clk);
    end
    write_limit(32);

    drain();
    $display("%0d items sent, %0d results checked", n_items, sb.n_results);
    $display("verdicts: cont %0d hit %0d sep %0d idle %0d giveup %0d", sb.n_verdict[0],
             sb.n_verdict[1], sb.n_verdict[2], sb.n_verdict[3], sb.n_verdict[4]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("gjk_simplex_collision_step_core_tb passed");
    else
      $display("gjk_simplex_collision_step_core_tb failed");
    $finish;
  end

endmodule
